/* sv/qtg_pkg.sv */
package qtg_pkg;

    localparam int AXES         = 8;
    localparam int AXIS_W       = 3;
    localparam int NCOEF        = 6;
    localparam int CSTORE_DEPTH = AXES * NCOEF;
    localparam int CSTORE_AW    = $clog2(CSTORE_DEPTH);
    localparam int OUT_COUNT    = (AXES < 8) ? AXES : 8;
    localparam int PADDR_W      = 3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic REG_FINAL_TIME = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_WR,
        ST_LD_TT,
        ST_LD_NINIT,
        ST_LD_NUM,
        ST_LD_ABS,
        ST_LD_DIV,
        ST_LD_WAIT,
        ST_LD_ROUND,
        ST_EV_RD,
        ST_EV_INIT,
        ST_EV_H1,
        ST_EV_H2,
        ST_EV_H3,
        ST_EV_H4,
        ST_EV_CONV,
        ST_EV_EMIT
    } state_t;

    function automatic logic [5:0] deriv_mult(input logic [1:0] d, input logic [2:0] i);
        logic [5:0] m;
        m = 6'd0;
        case (d)
            2'd0: m = (i <= 3'd5) ? 6'd1 : 6'd0;
            2'd1: begin
                case (i)
                    3'd1: m = 6'd1;
                    3'd2: m = 6'd2;
                    3'd3: m = 6'd3;
                    3'd4: m = 6'd4;
                    3'd5: m = 6'd5;
                    default: m = 6'd0;
                endcase
            end
            2'd2: begin
                case (i)
                    3'd2: m = 6'd2;
                    3'd3: m = 6'd6;
                    3'd4: m = 6'd12;
                    3'd5: m = 6'd20;
                    default: m = 6'd0;
                endcase
            end
            default: begin
                case (i)
                    3'd3: m = 6'd6;
                    3'd4: m = 6'd24;
                    3'd5: m = 6'd60;
                    default: m = 6'd0;
                endcase
            end
        endcase
        return m;
    endfunction

endpackage

/* sv/qtg_ram.sv */
module qtg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 48,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/qtg_div.sv */
module qtg_div import qtg_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [127:0] dividend,
    input  logic [31:0]  divisor,
    output logic         busy,
    output logic         done,
    output logic [127:0] quotient
);

    logic         busy_reg;
    logic         done_reg;
    logic [6:0]   cnt_reg;
    logic [127:0] quo_reg;
    logic [31:0]  rem_reg;
    logic [31:0]  div_reg;
    logic [32:0]  trial;
    logic         fits;

    assign trial = {rem_reg, quo_reg[127]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 7'd127) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? 32'(trial - {1'b0, div_reg}) : trial[31:0];
            quo_reg <= {quo_reg[126:0], fits};
            cnt_reg <= cnt_reg + 7'd1;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/quintic_trajectory_generator_core.sv */
// Quintic trajectory generator, up to AXES axes, signed Q16.16 data.
// Input channel (s_*): func 0 loads one axis's boundary conditions and derives
// its six Q32.32 coefficients from the final_time register; func 1 evaluates
// all axes at eval_time, clamped to final_time.
// Result channel (m_*): one transaction per axis on evaluate, in axis order,
// with position, velocity, acceleration and jerk; last marks the final axis.
// Loads produce no transaction.
// APB port: final_time at offset 0; write it only while the block is idle.
// Timing: one item at a time, s_ready is high only when idle.
// A load keeps s_ready low while it writes c0..c2, forms T squared, then for
// each of c3, c4, c5 runs setup, numerator and rounding plus 3, 4 or 5 passes
// through the bit-serial divider. An evaluate reads each axis's coefficients,
// runs 14 Horner steps (states H1..H4 each) on the shared 33x33 multiplier,
// a setup and a rounding step per derivative, and an emit step per axis.
// When m_ready is low the finished result holds in the output register and
// the next axis is computed; the block waits only when that one is also done.
// Reset clears the coefficient store (per-axis valid bits) and sets
// final_time to 1.0 s.
module quintic_trajectory_generator_core import qtg_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_func,
    input  logic [AXIS_W-1:0]         s_axis,
    input  logic signed [31:0]        s_start_pos,
    input  logic signed [31:0]        s_start_vel,
    input  logic signed [31:0]        s_start_acc,
    input  logic signed [31:0]        s_end_pos,
    input  logic signed [31:0]        s_end_vel,
    input  logic signed [31:0]        s_end_acc,
    input  logic [31:0]               s_eval_time,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [AXIS_W-1:0]         m_out_axis,
    output logic signed [31:0]        m_pos,
    output logic signed [31:0]        m_vel,
    output logic signed [31:0]        m_acc,
    output logic signed [31:0]        m_jerk,
    output logic                      m_last
);

    function automatic logic signed [63:0] sat71(input logic signed [70:0] v);
        logic signed [63:0] r;
        if ((&v[70:63]) || !(|v[70:63])) begin
            r = v[63:0];
        end else begin
            r = v[70] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sat82(input logic signed [81:0] v);
        logic signed [63:0] r;
        if ((&v[81:63]) || !(|v[81:63])) begin
            r = v[63:0];
        end else begin
            r = v[81] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [31:0] to_q16(input logic signed [63:0] a);
        logic signed [64:0] s;
        logic [48:0]        r;
        logic signed [31:0] o;
        s = {a[63], a} + 65'sd32768;
        r = s[64:16];
        if ((&r[48:31]) || !(|r[48:31])) begin
            o = r[31:0];
        end else begin
            o = r[48] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        return o;
    endfunction

    state_t state_reg, state_next;

    logic [31:0]              final_time_reg;
    logic [31:0]              tload_reg;
    logic [31:0]              teval_reg;
    logic [AXIS_W-1:0]        axis_reg;
    logic signed [31:0]       xs_reg, vs_reg, as_reg, xe_reg, ve_reg, ae_reg;
    logic [1:0]               cidx_reg;
    logic [2:0]               step_reg;
    logic [2:0]               cnt_reg;
    logic [63:0]              tt_reg;
    logic signed [127:0]      num_reg;
    logic                     neg_reg;
    logic [AXES-1:0]          valid_reg;
    logic [1:0]               d_reg;
    logic [2:0]               i_reg;
    logic signed [63:0]       coef_reg [NCOEF];
    logic signed [63:0]       acc_reg;
    logic signed [96:0]       w_reg;
    logic signed [70:0]       term_reg;
    logic signed [31:0]       res_reg [4];
    logic                     m_valid_reg;
    logic [AXIS_W-1:0]        m_axis_reg;
    logic signed [31:0]       m_pos_reg, m_vel_reg, m_acc_reg, m_jerk_reg;
    logic                     m_last_reg;

    logic [31:0]              tf;
    logic                     out_free;
    logic                     accept;
    logic signed [32:0]       mul_a, mul_b;
    logic signed [65:0]       mul_p;
    logic signed [127:0]      prod128, addend;
    logic signed [39:0]       d40, vs40, ve40, as40, ae40;
    logic signed [39:0]       kx, kv, ka;
    logic signed [63:0]       kv64, ka64;
    logic [5:0]               m_sel;
    logic signed [70:0]       term_c, init_c;
    logic signed [81:0]       h_sum;
    logic [127:0]             capped;
    logic signed [127:0]      rnd;
    logic [63:0]              rmag;
    logic signed [63:0]       rcoef;
    logic                     ram_we, ram_re;
    logic [CSTORE_AW-1:0]     ram_waddr, ram_raddr;
    logic [63:0]              ram_wdata, ram_rdata;
    logic signed [63:0]       rd_val;
    logic                     div_start, div_busy, div_done;
    logic [127:0]             div_q;
    logic [2:0]               coef_k;

    assign tf       = (final_time_reg == '0) ? 32'd1 : final_time_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_FINAL_TIME) ? final_time_reg : 32'd0;

    // boundary-condition weights for the selected coefficient
    assign d40  = 40'(xe_reg) - 40'(xs_reg);
    assign vs40 = 40'(vs_reg);
    assign ve40 = 40'(ve_reg);
    assign as40 = 40'(as_reg);
    assign ae40 = 40'(ae_reg);

    always_comb begin
        case (cidx_reg)
            2'd0: begin
                kx = 40'sd20 * d40;
                kv = -(40'sd8 * ve40 + 40'sd12 * vs40);
                ka = -(40'sd3 * as40 - ae40);
            end
            2'd1: begin
                kx = -(40'sd30 * d40);
                kv = 40'sd14 * ve40 + 40'sd16 * vs40;
                ka = 40'sd3 * as40 - 40'sd2 * ae40;
            end
            default: begin
                kx = 40'sd12 * d40;
                kv = -(40'sd6 * (ve40 + vs40));
                ka = -(as40 - ae40);
            end
        endcase
    end

    assign kv64 = 64'(kv);
    assign ka64 = 64'(ka);

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LD_TT: begin
                mul_a = {1'b0, tload_reg};
                mul_b = {1'b0, tload_reg};
            end
            ST_LD_NUM: begin
                case (cnt_reg)
                    3'd0: begin
                        mul_a = {1'b0, kv64[31:0]};
                        mul_b = {1'b0, tload_reg};
                    end
                    3'd1: begin
                        mul_a = {kv64[63], kv64[63:32]};
                        mul_b = {1'b0, tload_reg};
                    end
                    3'd2: begin
                        mul_a = {1'b0, ka64[31:0]};
                        mul_b = {1'b0, tt_reg[31:0]};
                    end
                    3'd3: begin
                        mul_a = {ka64[63], ka64[63:32]};
                        mul_b = {1'b0, tt_reg[31:0]};
                    end
                    3'd4: begin
                        mul_a = {1'b0, ka64[31:0]};
                        mul_b = {1'b0, tt_reg[63:32]};
                    end
                    default: begin
                        mul_a = {ka64[63], ka64[63:32]};
                        mul_b = {1'b0, tt_reg[63:32]};
                    end
                endcase
            end
            ST_EV_H1: begin
                mul_a = {1'b0, acc_reg[31:0]};
                mul_b = {1'b0, teval_reg};
            end
            ST_EV_H2: begin
                mul_a = {acc_reg[63], acc_reg[63:32]};
                mul_b = {1'b0, teval_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign prod128 = {{62{mul_p[65]}}, mul_p};

    always_comb begin
        case (cnt_reg)
            3'd0:    addend = prod128 <<< 16;
            3'd1:    addend = prod128 <<< 48;
            3'd2:    addend = prod128;
            3'd3:    addend = prod128 <<< 32;
            3'd4:    addend = prod128 <<< 32;
            default: addend = prod128 <<< 64;
        endcase
    end

    // quotient cap at 2^100, then rounding to Q32.32
    assign capped = ((|div_q[127:101]) || (div_q[100] && (|div_q[99:0])))
                    ? (128'd1 << 100) : div_q;
    assign rnd    = num_reg + 128'sd65536;
    assign rmag   = (|rnd[127:80]) ? {1'b0, {63{1'b1}}} : rnd[80:17];
    assign rcoef  = neg_reg ? -$signed(rmag) : $signed(rmag);
    assign coef_k = {1'b0, cidx_reg} + 3'd3;

    // Horner datapath
    assign m_sel  = deriv_mult(d_reg, i_reg);
    assign term_c = $signed({1'b0, m_sel}) * coef_reg[i_reg];
    assign init_c = $signed({1'b0, deriv_mult(d_reg, 3'd5)}) * coef_reg[5];
    assign h_sum  = $signed(w_reg[81:0]) + 82'(term_reg);
    assign rd_val = valid_reg[axis_reg] ? $signed(ram_rdata) : 64'sd0;

    // coefficient store
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = CSTORE_AW'(CSTORE_AW'(axis_reg) * CSTORE_AW'(NCOEF));
        ram_wdata = '0;
        case (state_reg)
            ST_LD_WR: begin
                ram_we    = 1'b1;
                ram_waddr = CSTORE_AW'(CSTORE_AW'(axis_reg) * CSTORE_AW'(NCOEF)
                            + CSTORE_AW'(cnt_reg));
                case (cnt_reg)
                    3'd0:    ram_wdata = 64'(xs_reg) <<< 16;
                    3'd1:    ram_wdata = 64'(vs_reg) <<< 16;
                    default: ram_wdata = 64'(as_reg) <<< 15;
                endcase
            end
            ST_LD_ROUND: begin
                ram_we    = 1'b1;
                ram_waddr = CSTORE_AW'(CSTORE_AW'(axis_reg) * CSTORE_AW'(NCOEF)
                            + CSTORE_AW'(coef_k));
                ram_wdata = rcoef;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_re    = (state_reg == ST_EV_RD) && (cnt_reg < 3'(NCOEF));
    assign ram_raddr = CSTORE_AW'(CSTORE_AW'(axis_reg) * CSTORE_AW'(NCOEF)
                       + CSTORE_AW'(cnt_reg));

    qtg_ram #(
        .WIDTH (64),
        .DEPTH (CSTORE_DEPTH)
    ) u_cstore (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_start = (state_reg == ST_LD_DIV);

    qtg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg << 16),
        .divisor  (tload_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == FUNC_EVAL) begin
                        state_next = ST_EV_RD;
                    end else if (int'(s_axis) < AXES) begin
                        state_next = ST_LD_WR;
                    end
                end
            end
            ST_LD_WR:    state_next = (cnt_reg == 3'd2) ? ST_LD_TT : ST_LD_WR;
            ST_LD_TT:    state_next = ST_LD_NINIT;
            ST_LD_NINIT: state_next = ST_LD_NUM;
            ST_LD_NUM:   state_next = (cnt_reg == 3'd5) ? ST_LD_ABS : ST_LD_NUM;
            ST_LD_ABS:   state_next = ST_LD_DIV;
            ST_LD_DIV:   state_next = ST_LD_WAIT;
            ST_LD_WAIT: begin
                if (div_done) begin
                    state_next = (step_reg + 3'd1 == coef_k) ? ST_LD_ROUND : ST_LD_DIV;
                end
            end
            ST_LD_ROUND: state_next = (cidx_reg == 2'd2) ? ST_IDLE : ST_LD_NINIT;
            ST_EV_RD:    state_next = (cnt_reg == 3'(NCOEF)) ? ST_EV_INIT : ST_EV_RD;
            ST_EV_INIT:  state_next = ST_EV_H1;
            ST_EV_H1:    state_next = ST_EV_H2;
            ST_EV_H2:    state_next = ST_EV_H3;
            ST_EV_H3:    state_next = ST_EV_H4;
            ST_EV_H4:    state_next = (i_reg == {1'b0, d_reg}) ? ST_EV_CONV : ST_EV_H1;
            ST_EV_CONV:  state_next = (d_reg == 2'd3) ? ST_EV_EMIT : ST_EV_INIT;
            ST_EV_EMIT: begin
                if (out_free) begin
                    state_next = (axis_reg == AXIS_W'(OUT_COUNT - 1)) ? ST_IDLE : ST_EV_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            final_time_reg <= 32'd65536;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (psel && penable && pwrite && pready && paddr[2] == REG_FINAL_TIME) begin
                final_time_reg <= pwdata;
            end
            if (state_reg == ST_LD_WR) begin
                valid_reg[axis_reg] <= 1'b1;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_EV_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    axis_reg  <= (s_func == FUNC_EVAL) ? '0 : s_axis;
                    xs_reg    <= s_start_pos;
                    vs_reg    <= s_start_vel;
                    as_reg    <= s_start_acc;
                    xe_reg    <= s_end_pos;
                    ve_reg    <= s_end_vel;
                    ae_reg    <= s_end_acc;
                    tload_reg <= tf;
                    teval_reg <= (s_eval_time > tf) ? tf : s_eval_time;
                    cnt_reg   <= '0;
                    cidx_reg  <= '0;
                    d_reg     <= '0;
                end
            end
            ST_LD_WR:    cnt_reg <= cnt_reg + 3'd1;
            ST_LD_TT:    tt_reg  <= mul_p[63:0];
            ST_LD_NINIT: begin
                num_reg <= 128'(kx) <<< 32;
                cnt_reg <= '0;
            end
            ST_LD_NUM: begin
                num_reg <= num_reg + addend;
                cnt_reg <= cnt_reg + 3'd1;
            end
            ST_LD_ABS: begin
                neg_reg  <= num_reg[127];
                num_reg  <= num_reg[127] ? -num_reg : num_reg;
                step_reg <= '0;
            end
            ST_LD_WAIT: begin
                if (div_done) begin
                    num_reg  <= capped;
                    step_reg <= step_reg + 3'd1;
                end
            end
            ST_LD_ROUND: cidx_reg <= cidx_reg + 2'd1;
            ST_EV_RD: begin
                if (cnt_reg != 3'd0) begin
                    coef_reg[cnt_reg - 3'd1] <= rd_val;
                end
                cnt_reg <= cnt_reg + 3'd1;
                d_reg   <= '0;
            end
            ST_EV_INIT: begin
                acc_reg <= sat71(init_c);
                i_reg   <= 3'd4;
            end
            ST_EV_H1: begin
                w_reg    <= {{31{mul_p[65]}}, mul_p};
                term_reg <= term_c;
            end
            ST_EV_H2:    w_reg <= w_reg + ({{31{mul_p[65]}}, mul_p} <<< 32);
            ST_EV_H3:    w_reg <= (w_reg + 97'sd32768) >>> 16;
            ST_EV_H4: begin
                acc_reg <= sat82(h_sum);
                i_reg   <= i_reg - 3'd1;
            end
            ST_EV_CONV: begin
                res_reg[d_reg] <= to_q16(acc_reg);
                d_reg          <= d_reg + 2'd1;
            end
            ST_EV_EMIT: begin
                if (out_free) begin
                    m_axis_reg <= axis_reg;
                    m_pos_reg  <= res_reg[0];
                    m_vel_reg  <= res_reg[1];
                    m_acc_reg  <= res_reg[2];
                    m_jerk_reg <= res_reg[3];
                    m_last_reg <= (axis_reg == AXIS_W'(OUT_COUNT - 1));
                    axis_reg   <= axis_reg + AXIS_W'(1);
                    cnt_reg    <= '0;
                end
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_out_axis = m_axis_reg;
    assign m_pos      = m_pos_reg;
    assign m_vel      = m_vel_reg;
    assign m_acc      = m_acc_reg;
    assign m_jerk     = m_jerk_reg;
    assign m_last     = m_last_reg;

`ifndef NO_ASSERTIONS
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !div_busy)
        else $error("divider busy while idle");

    a_last_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_out_axis == AXIS_W'(OUT_COUNT - 1))
        else $error("last flag on wrong axis");

    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_func == FUNC_LOAD && !m_valid |=> !m_valid)
        else $error("load produced a transaction");
`endif

endmodule
